/* sv/lri_pkg.sv */
package lri_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 24;

    // result queue entries, and the limit on items in flight
    localparam int FIFO_DEPTH = 16;

    // side codes
    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    // register index of the inset register
    localparam logic REG_INSET = 1'b0;

endpackage

/* sv/line_rect_intersection_unit.sv */
// channel   ports                                      handshake
// -------   -----------------------------------------  ------------------------------
// command   i_line_*, i_rect_*                         start & !busy
// result    o_point_x/y, o_side_hit, o_found, o_last   o_result_valid, one cycle
// config    psel penable pwrite paddr pwdata prdata    psel & penable & pwrite, pready=1
//
// an item enters the arithmetic pipeline in any cycle in which busy is low; its hits reach the
// result queue through stages 1 to 4, the range check, the divider, rounding and saturation (the
// restoring divider takes one quotient bit per stage, COORD_BITS+2 stages). the result port
// drains one beat per cycle, so an item with k hits gives max(k,1) beats, four at most; busy
// rises while FIFO_DEPTH items are in flight, counting the pipeline and the queue together.
// reset is synchronous, active low; it clears valid bits, queue pointers and inset.
// the receiver cannot stall: results leave on the cycle they are shown.
module line_rect_intersection_unit #(
    parameter int COORD_BITS = lri_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_line_x1,
    input  logic signed [COORD_BITS-1:0] i_line_y1,
    input  logic signed [COORD_BITS-1:0] i_line_x2,
    input  logic signed [COORD_BITS-1:0] i_line_y2,
    input  logic signed [COORD_BITS-1:0] i_rect_left,
    input  logic signed [COORD_BITS-1:0] i_rect_top,
    input  logic        [COORD_BITS-2:0] i_rect_width,
    input  logic        [COORD_BITS-2:0] i_rect_height,
    output logic                         o_result_valid,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic        [1:0]            o_side_hit,
    output logic                         o_found,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic        [2:0]            paddr,
    input  logic        [31:0]           pwdata,
    output logic        [31:0]           prdata,
    output logic                         pready
);

    localparam int CB  = COORD_BITS;
    localparam int EW  = CB + 2;        // moved edges
    localparam int DXW = CB + 1;        // line direction
    localparam int DNW = CB + 1;        // divisor magnitude
    localparam int OW  = CB + 3;        // operand differences and final sums
    localparam int PW  = 2 * CB + 5;    // products
    localparam int QB  = CB + 2;        // quotient bits
    localparam int NS  = 4;             // sides
    localparam int DEP = lri_pkg::FIFO_DEPTH;
    localparam int AW  = $clog2(DEP);
    localparam int CW  = $clog2(DEP + 1);
    localparam logic signed [OW-1:0] VMAX = {{(OW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [OW-1:0] VMIN = ~VMAX;

    function automatic logic signed [CB-1:0] sat(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] c;
        c = v;
        if (v > VMAX) c = VMAX;
        if (v < VMIN) c = VMIN;
        return c[CB-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [7:0] r_inset;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == lri_pkg::REG_INSET) ? {24'd0, r_inset} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inset <= 8'd0;
        end else if (cfg_wr && paddr[2] == lri_pkg::REG_INSET) begin
            r_inset <= pwdata[7:0];
        end
    end

    // ---------------- stage 1: moved corners, direction ----------------
    logic                  accept;
    logic                  r1_vld;
    logic signed [CB-1:0]  r1_x1, r1_y1;
    logic signed [EW-1:0]  r1_l, r1_t, r1_r, r1_b;
    logic signed [DXW-1:0] r1_dx, r1_dy;
    logic signed [EW-1:0]  ins_e, w_e, h_e, left_e, top_e;

    assign accept = start && !busy;
    assign ins_e  = $signed({{(EW-8){1'b0}}, r_inset});
    assign w_e    = $signed({3'b000, i_rect_width});
    assign h_e    = $signed({3'b000, i_rect_height});
    assign left_e = EW'(i_rect_left);
    assign top_e  = EW'(i_rect_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
        r1_x1 <= i_line_x1;
        r1_y1 <= i_line_y1;
        r1_l  <= left_e + ins_e;
        r1_t  <= top_e + ins_e;
        r1_r  <= left_e + w_e - ins_e;
        r1_b  <= top_e + h_e - ins_e;
        r1_dx <= DXW'(i_line_x2) - DXW'(i_line_x1);
        r1_dy <= DXW'(i_line_y2) - DXW'(i_line_y1);
    end

    // ---------------- stage 2: per-side operands ----------------
    logic                  r2_vld;
    logic signed [OW-1:0]  r2_cb [NS], r2_lo [NS], r2_hi [NS];
    logic signed [DXW-1:0] r2_da [NS];
    logic        [DNW-1:0] r2_den [NS];
    logic                  r2_dneg [NS], r2_ok [NS];
    logic signed [CB-1:0]  r2_a1 [NS];
    logic signed [EW-1:0]  r2_c [NS];

    logic signed [CB-1:0]  s_a1 [NS], s_b1 [NS];
    logic signed [DXW-1:0] s_da [NS], s_db [NS];
    logic signed [EW-1:0]  s_c [NS], s_e0 [NS], s_e1 [NS], s_lo [NS], s_hi [NS];

    // line through (a1,b1) with direction (da,db) against side b = c, a in [e0,e1]
    always_comb begin
        for (int l = 0; l < NS; l++) begin
            case (2'(l))
                lri_pkg::SIDE_TOP: begin
                    s_a1[l] = r1_x1; s_b1[l] = r1_y1; s_da[l] = r1_dx; s_db[l] = r1_dy;
                    s_c[l] = r1_t; s_e0[l] = r1_l; s_e1[l] = r1_r;
                end
                lri_pkg::SIDE_RIGHT: begin
                    s_a1[l] = r1_y1; s_b1[l] = r1_x1; s_da[l] = r1_dy; s_db[l] = r1_dx;
                    s_c[l] = r1_r; s_e0[l] = r1_t; s_e1[l] = r1_b;
                end
                lri_pkg::SIDE_BOTTOM: begin
                    s_a1[l] = r1_x1; s_b1[l] = r1_y1; s_da[l] = r1_dx; s_db[l] = r1_dy;
                    s_c[l] = r1_b; s_e0[l] = r1_r; s_e1[l] = r1_l;
                end
                default: begin
                    s_a1[l] = r1_y1; s_b1[l] = r1_x1; s_da[l] = r1_dy; s_db[l] = r1_dx;
                    s_c[l] = r1_l; s_e0[l] = r1_b; s_e1[l] = r1_t;
                end
            endcase
            s_lo[l] = (s_e0[l] < s_e1[l]) ? s_e0[l] : s_e1[l];
            s_hi[l] = (s_e0[l] < s_e1[l]) ? s_e1[l] : s_e0[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        for (int l = 0; l < NS; l++) begin
            r2_cb[l]   <= OW'(s_c[l]) - OW'(s_b1[l]);
            r2_lo[l]   <= OW'(s_lo[l]) - OW'(s_a1[l]);
            r2_hi[l]   <= OW'(s_hi[l]) - OW'(s_a1[l]);
            r2_da[l]   <= s_da[l];
            r2_den[l]  <= s_db[l][DXW-1] ? DNW'(-s_db[l]) : DNW'(s_db[l]);
            r2_dneg[l] <= s_db[l][DXW-1];
            r2_ok[l]   <= (s_db[l] != '0) && (s_e0[l] != s_e1[l]);
            r2_a1[l]   <= s_a1[l];
            r2_c[l]    <= s_c[l];
        end
    end

    // ---------------- stage 3: products ----------------
    logic                  r3_vld;
    logic signed [PW-1:0]  r3_t0 [NS], r3_pl [NS], r3_ph [NS];
    logic        [DNW-1:0] r3_den [NS];
    logic                  r3_dneg [NS], r3_ok [NS];
    logic signed [CB-1:0]  r3_a1 [NS];
    logic signed [EW-1:0]  r3_c [NS];
    logic signed [DNW:0]   den_s [NS];

    always_comb begin
        for (int l = 0; l < NS; l++) begin
            den_s[l] = $signed({1'b0, r2_den[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        for (int l = 0; l < NS; l++) begin
            r3_t0[l]   <= PW'(r2_cb[l]) * PW'(r2_da[l]);
            r3_pl[l]   <= PW'(r2_lo[l]) * PW'(den_s[l]);
            r3_ph[l]   <= PW'(r2_hi[l]) * PW'(den_s[l]);
            r3_den[l]  <= r2_den[l];
            r3_dneg[l] <= r2_dneg[l];
            r3_ok[l]   <= r2_ok[l];
            r3_a1[l]   <= r2_a1[l];
            r3_c[l]    <= r2_c[l];
        end
    end

    // ---------------- stage 4: sign of numerator follows the divisor ----------------
    logic                  r4_vld;
    logic signed [PW-1:0]  r4_t [NS], r4_pl [NS], r4_ph [NS];
    logic        [DNW-1:0] r4_den [NS];
    logic                  r4_ok [NS];
    logic signed [CB-1:0]  r4_a1 [NS];
    logic signed [EW-1:0]  r4_c [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        for (int l = 0; l < NS; l++) begin
            r4_t[l]   <= r3_dneg[l] ? -r3_t0[l] : r3_t0[l];
            r4_pl[l]  <= r3_pl[l];
            r4_ph[l]  <= r3_ph[l];
            r4_den[l] <= r3_den[l];
            r4_ok[l]  <= r3_ok[l];
            r4_a1[l]  <= r3_a1[l];
            r4_c[l]   <= r3_c[l];
        end
    end

    // ---------------- stage 5 and divider: index 0 is the range check ----------------
    logic                  rd_vld [QB+1];
    logic        [PW-1:0]  rd_rem [QB+1][NS];
    logic        [QB-1:0]  rd_q   [QB+1][NS];
    logic        [DNW-1:0] rd_den [QB+1][NS];
    logic                  rd_hit [QB+1][NS], rd_neg [QB+1][NS];
    logic signed [CB-1:0]  rd_a1  [QB+1][NS];
    logic signed [EW-1:0]  rd_c   [QB+1][NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_vld[0] <= 1'b0;
        end else begin
            rd_vld[0] <= r4_vld;
        end
        for (int l = 0; l < NS; l++) begin
            rd_hit[0][l] <= r4_ok[l] && !(r4_pl[l] > r4_t[l]) && !(r4_t[l] > r4_ph[l]);
            rd_neg[0][l] <= r4_t[l][PW-1];
            rd_rem[0][l] <= r4_t[l][PW-1] ? PW'(-r4_t[l]) : PW'(r4_t[l]);
            rd_q[0][l]   <= '0;
            rd_den[0][l] <= r4_den[l];
            rd_a1[0][l]  <= r4_a1[l];
            rd_c[0][l]   <= r4_c[l];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar d = 0; d < QB; d++) begin : g_div
        localparam int SH = QB - 1 - d;
        logic [PW-1:0] dsh [NS];

        always_comb begin
            for (int l = 0; l < NS; l++) begin
                dsh[l] = PW'(rd_den[d][l]) << SH;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rd_vld[d+1] <= 1'b0;
            end else begin
                rd_vld[d+1] <= rd_vld[d];
            end
            for (int l = 0; l < NS; l++) begin
                if (rd_rem[d][l] >= dsh[l]) begin
                    rd_rem[d+1][l] <= rd_rem[d][l] - dsh[l];
                    rd_q[d+1][l]   <= rd_q[d][l] | (QB'(1) << SH);
                end else begin
                    rd_rem[d+1][l] <= rd_rem[d][l];
                    rd_q[d+1][l]   <= rd_q[d][l];
                end
                rd_den[d+1][l] <= rd_den[d][l];
                rd_hit[d+1][l] <= rd_hit[d][l];
                rd_neg[d+1][l] <= rd_neg[d][l];
                rd_a1[d+1][l]  <= rd_a1[d][l];
                rd_c[d+1][l]   <= rd_c[d][l];
            end
        end
    end

    // ---------------- round to nearest, ties away from zero ----------------
    logic                 r6_vld;
    logic        [QB:0]   r6_q [NS];
    logic                 r6_hit [NS], r6_neg [NS];
    logic signed [CB-1:0] r6_a1 [NS];
    logic signed [EW-1:0] r6_c [NS];
    logic        [DNW:0]  rem2 [NS];

    always_comb begin
        for (int l = 0; l < NS; l++) begin
            rem2[l] = {rd_rem[QB][l][DNW-1:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= rd_vld[QB];
        end
        for (int l = 0; l < NS; l++) begin
            r6_q[l]   <= {1'b0, rd_q[QB][l]}
                       + ((rem2[l] >= {1'b0, rd_den[QB][l]}) ? (QB+1)'(1) : '0);
            r6_hit[l] <= rd_hit[QB][l];
            r6_neg[l] <= rd_neg[QB][l];
            r6_a1[l]  <= rd_a1[QB][l];
            r6_c[l]   <= rd_c[QB][l];
        end
    end

    // ---------------- crossing coordinate and saturation ----------------
    logic                 r7_vld;
    logic signed [CB-1:0] r7_v [NS], r7_c [NS];
    logic                 r7_hit [NS];
    logic signed [OW-1:0] q_s [NS];

    always_comb begin
        for (int l = 0; l < NS; l++) begin
            q_s[l] = $signed(r6_q[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        for (int l = 0; l < NS; l++) begin
            r7_v[l]   <= sat(OW'(r6_a1[l]) + (r6_neg[l] ? -q_s[l] : q_s[l]));
            r7_c[l]   <= sat(OW'(r6_c[l]));
            r7_hit[l] <= r6_hit[l];
        end
    end

    // ---------------- result queue, one entry per item ----------------
    logic        [NS-1:0] r_fq_hit [DEP];
    logic signed [CB-1:0] r_fq_px  [DEP][NS];
    logic signed [CB-1:0] r_fq_py  [DEP][NS];
    logic        [AW-1:0] r_wr, r_rd;
    logic        [CW-1:0] r_count;   // items accepted and not yet fully sent
    logic        [CW-1:0] r_fill;    // entries sitting in the queue
    logic        [NS-1:0] r_done;    // sides of the head entry already sent

    always_ff @(posedge i_clk) begin
        if (r7_vld) begin
            for (int l = 0; l < NS; l++) begin
                r_fq_hit[r_wr][l] <= r7_hit[l];
                if (l == int'(lri_pkg::SIDE_RIGHT) || l == int'(lri_pkg::SIDE_LEFT)) begin
                    r_fq_px[r_wr][l] <= r7_c[l];
                    r_fq_py[r_wr][l] <= r7_v[l];
                end else begin
                    r_fq_px[r_wr][l] <= r7_v[l];
                    r_fq_py[r_wr][l] <= r7_c[l];
                end
            end
        end
    end

    // head entry: lowest unsent hit side is registered onto the result port
    logic [NS-1:0] rem_mask, after_mask;
    logic [1:0]    sel;
    logic          head_vld, pop;

    assign head_vld = (r_fill != '0);
    assign rem_mask = r_fq_hit[r_rd] & ~r_done;

    always_comb begin
        if (rem_mask[0])      sel = lri_pkg::SIDE_TOP;
        else if (rem_mask[1]) sel = lri_pkg::SIDE_RIGHT;
        else if (rem_mask[2]) sel = lri_pkg::SIDE_BOTTOM;
        else                  sel = lri_pkg::SIDE_LEFT;
        after_mask = rem_mask & ~(NS'(1) << sel);
    end

    assign pop  = head_vld && (after_mask == '0);
    assign busy = (r_count == CW'(DEP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr           <= '0;
            r_rd           <= '0;
            r_count        <= '0;
            r_fill         <= '0;
            r_done         <= '0;
            o_result_valid <= 1'b0;
        end else begin
            if (r7_vld) r_wr <= r_wr + AW'(1);
            if (pop)    r_rd <= r_rd + AW'(1);
            r_count <= r_count + (accept ? CW'(1) : '0) - (pop ? CW'(1) : '0);
            r_fill  <= r_fill + (r7_vld ? CW'(1) : '0) - (pop ? CW'(1) : '0);
            if (pop)           r_done <= '0;
            else if (head_vld) r_done <= r_done | (NS'(1) << sel);
            o_result_valid <= head_vld;
        end
        // result beat payload
        if (rem_mask == '0) begin
            o_point_x  <= '0;
            o_point_y  <= '0;
            o_side_hit <= lri_pkg::SIDE_TOP;
            o_found    <= 1'b0;
        end else begin
            o_point_x  <= r_fq_px[r_rd][sel];
            o_point_y  <= r_fq_py[r_rd][sel];
            o_side_hit <= sel;
            o_found    <= 1'b1;
        end
        o_last <= (after_mask == '0);
    end

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEP) && r_fill <= r_count)
        else $error("in-flight item count out of range");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_found |-> o_last)
        else $error("miss beat not marked last");

    a_accept_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_count != '0)
        else $error("accepted item not counted");

endmodule

/* tb/tb_line_rect_intersection_unit.sv */
`timescale 1ns / 1ps

module tb_line_rect_intersection_unit;

    localparam int CB = 24;
    localparam int PIPE_LAT = CB + 9;
    localparam longint CYCLE_LIMIT = 400000;

    // one command beat
    typedef struct packed {
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic signed [CB-1:0] x2;
        logic signed [CB-1:0] y2;
        logic signed [CB-1:0] left;
        logic signed [CB-1:0] top;
        logic [CB-2:0]        width;
        logic [CB-2:0]        height;
    } t_line_rect;

    // one result beat
    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic [1:0]           side;
        logic                 found;
        logic                 last;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CB-1:0] i_line_x1 = '0, i_line_y1 = '0, i_line_x2 = '0, i_line_y2 = '0;
    logic signed [CB-1:0] i_rect_left = '0, i_rect_top = '0;
    logic [CB-2:0] i_rect_width = '0, i_rect_height = '0;
    logic o_result_valid;
    logic signed [CB-1:0] o_point_x, o_point_y;
    logic [1:0] o_side_hit;
    logic o_found, o_last;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    line_rect_intersection_unit #(.COORD_BITS(CB)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_line_rect cmd_queue[$];
    t_hit       hits_due[$];
    int         err_count = 0;
    longint     cycle_count = 0;
    int         send_idle_pct = 0;
    logic [7:0] cur_inset = '0;

    // ---------------------------------------------------------------------
    // predictor: exact crossing of the infinite line with each moved side
    // ---------------------------------------------------------------------

    // round n/d to nearest, ties away from zero, d > 0
    function automatic longint div_round(logic signed [127:0] n, longint d);
        logic signed [127:0] mag, q, r;
        mag = (n < 0) ? -n : n;
        q = mag / d;
        r = mag - q * d;
        if (r >= d - r) q = q + 1;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    // line through (a1,b1) direction (da,db) against b = c, a in [e0,e1]
    function automatic bit cross_side(longint a1, longint b1, longint da, longint db,
                                      longint c, longint e0, longint e1,
                                      output longint a_out);
        longint lo, hi, den;
        logic signed [127:0] t;
        a_out = 0;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        if (db == 0 || e0 == e1) return 1'b0;
        den = db;
        t = 128'(signed'(c - b1)) * 128'(signed'(da));
        if (den < 0) begin
            den = -den;
            t = -t;
        end
        if (128'(signed'(lo - a1)) * den > t || t > 128'(signed'(hi - a1)) * den)
            return 1'b0;
        a_out = a1 + div_round(t, den);
        return 1'b1;
    endfunction

    function automatic logic [CB-1:0] clamp_coord(longint v);
        longint mx, mn;
        mx = (longint'(1) <<< (CB - 1)) - 1;
        mn = -mx - 1;
        if (v > mx) v = mx;
        if (v < mn) v = mn;
        return v[CB-1:0];
    endfunction

    task automatic predict_hits(t_line_rect c);
        longint x1, y1, dx, dy, lft, tp, rt, bt, v, px, py;
        bit ok;
        t_hit h;
        int n;
        x1 = c.x1; y1 = c.y1;
        dx = longint'(c.x2) - x1;
        dy = longint'(c.y2) - y1;
        lft = longint'(c.left) + cur_inset;
        tp  = longint'(c.top) + cur_inset;
        rt  = longint'(c.left) + longint'(c.width) - cur_inset;
        bt  = longint'(c.top) + longint'(c.height) - cur_inset;
        n = 0;
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: begin
                    ok = cross_side(x1, y1, dx, dy, tp, lft, rt, v); px = v; py = tp;
                end
                1: begin
                    ok = cross_side(y1, x1, dy, dx, rt, tp, bt, v); px = rt; py = v;
                end
                2: begin
                    ok = cross_side(x1, y1, dx, dy, bt, rt, lft, v); px = v; py = bt;
                end
                default: begin
                    ok = cross_side(y1, x1, dy, dx, lft, bt, tp, v); px = lft; py = v;
                end
            endcase
            if (ok) begin
                h.px = clamp_coord(px);
                h.py = clamp_coord(py);
                h.side = s[1:0];
                h.found = 1'b1;
                h.last = 1'b0;
                hits_due.push_back(h);
                n++;
            end
        end
        if (n == 0) begin
            h = '0;
            h.side = lri_pkg::SIDE_TOP;
            h.last = 1'b1;
            hits_due.push_back(h);
        end else begin
            hits_due[$].last = 1'b1;
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch @%0d: %s", cycle_count, what);
        err_count++;
    endtask

    // ---------------------------------------------------------------------
    // driver: pops a pending command when the port is free, idles at random
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (!start || !busy) begin
                // previous beat taken (or none held): load the next one
                if (start) predict_hits(cmd_queue.pop_front());
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    start <= 1'b1;
                    {i_line_x1, i_line_y1, i_line_x2, i_line_y2,
                     i_rect_left, i_rect_top, i_rect_width, i_rect_height} <= cmd_queue[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // monitor: every strobed result beat checked against the oldest expected
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_hit exp_h;
        if (i_rst_n && o_result_valid) begin
            if (hits_due.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                exp_h = hits_due.pop_front();
                if (o_point_x !== exp_h.px)
                    report_mismatch($sformatf("point_x %0d exp %0d", o_point_x, exp_h.px));
                if (o_point_y !== exp_h.py)
                    report_mismatch($sformatf("point_y %0d exp %0d", o_point_y, exp_h.py));
                if (o_side_hit !== exp_h.side)
                    report_mismatch($sformatf("side_hit %0d exp %0d", o_side_hit, exp_h.side));
                if (o_found !== exp_h.found)
                    report_mismatch($sformatf("found %0b exp %0b", o_found, exp_h.found));
                if (o_last !== exp_h.last)
                    report_mismatch($sformatf("last %0b exp %0b", o_last, exp_h.last));
            end
        end
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            report_mismatch("timeout waiting for result beats");
            $display("tb_line_rect_intersection_unit: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    function automatic logic [CB-1:0] rnd_coord(int span);
        // mostly small coordinates so lines actually cross, sometimes any value
        if ($urandom_range(9) == 0) return CB'($urandom);
        return CB'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic t_line_rect rnd_cmd();
        t_line_rect c;
        int span;
        span = ($urandom_range(3) == 0) ? 8000000 : 20000;
        c.left   = rnd_coord(span);
        c.top    = rnd_coord(span);
        c.width  = ($urandom_range(7) == 0) ? (CB-1)'($urandom) : (CB-1)'($urandom_range(span));
        c.height = ($urandom_range(7) == 0) ? (CB-1)'($urandom) : (CB-1)'($urandom_range(span));
        case ($urandom_range(5))
            0: begin  // horizontal line
                c.x1 = rnd_coord(span); c.x2 = rnd_coord(span);
                c.y1 = rnd_coord(span); c.y2 = c.y1;
            end
            1: begin  // vertical line
                c.y1 = rnd_coord(span); c.y2 = rnd_coord(span);
                c.x1 = rnd_coord(span); c.x2 = c.x1;
            end
            2: begin  // through a corner on a diagonal
                c.x1 = c.left; c.y1 = c.top;
                c.x2 = CB'(c.left + 256); c.y2 = CB'(c.top + 256);
            end
            default: begin
                c.x1 = rnd_coord(span); c.y1 = rnd_coord(span);
                c.x2 = rnd_coord(span); c.y2 = rnd_coord(span);
            end
        endcase
        return c;
    endfunction

    function automatic t_line_rect mk(int x1, int y1, int x2, int y2,
                                      int l, int t, int w, int h);
        t_line_rect c;
        c.x1 = CB'(x1); c.y1 = CB'(y1); c.x2 = CB'(x2); c.y2 = CB'(y2);
        c.left = CB'(l); c.top = CB'(t); c.width = (CB-1)'(w); c.height = (CB-1)'(h);
        return c;
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_inset(logic [7:0] v);
        apb_write(3'(lri_pkg::REG_INSET) << 2, {24'd0, v});
        cur_inset = v;
    endtask

    // wait until every queued command is sent and every beat is back
    task automatic drain();
        while (cmd_queue.size() > 0 || start || hits_due.size() > 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    localparam int MAXC = 8388607;
    localparam int MINC = -8388608;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: plain cross, corners, parallel, degenerate, extremes
        set_inset(8'd0);
        send_idle_pct = 13;
        cmd_queue.push_back(mk(0, 0, 2560, 2560, 256, 512, 1024, 512));
        cmd_queue.push_back(mk(0, 0, 256, 256, 0, 0, 2560, 2560));       // diagonal corners
        cmd_queue.push_back(mk(0, 100, 900, 100, 0, 100, 2560, 2560));   // lies on top side
        cmd_queue.push_back(mk(50, 0, 50, 900, 0, 0, 2560, 2560));       // vertical cross
        cmd_queue.push_back(mk(7, 7, 7, 7, 0, 0, 2560, 2560));           // degenerate
        cmd_queue.push_back(mk(0, 5000, 10, 5000, 0, 0, 256, 256));      // miss
        cmd_queue.push_back(mk(0, 0, 3, 7, -300, -300, 600, 600));       // rounding
        cmd_queue.push_back(mk(MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC));
        cmd_queue.push_back(mk(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC));
        cmd_queue.push_back(mk(0, 0, 1, 0, 0, 0, 0, 0));                 // zero-size rect
        cmd_queue.push_back(mk(0, 0, 1, 1, 0, 0, 0, 1000));              // zero-width
        cmd_queue.push_back(mk(MINC, 0, MAXC, 1, -100, -100, MAXC, 200));
        drain();

        // inset extremes: max inset crosses over small rectangles
        set_inset(8'd255);
        cmd_queue.push_back(mk(0, 0, 256, 256, 0, 0, 256, 256));
        cmd_queue.push_back(mk(0, 0, 256, 256, 0, 0, 510, 510));         // collapses to point
        cmd_queue.push_back(mk(-1000, 300, 1000, 310, 0, 0, 1000, 1000));
        cmd_queue.push_back(mk(0, 0, 1, 3, MAXC - 10, MAXC - 10, MAXC, MAXC));
        for (int i = 0; i < 110; i++) cmd_queue.push_back(rnd_cmd());
        drain();

        // sender idles heavily
        set_inset(8'($urandom_range(1, 254)));
        send_idle_pct = 58;
        for (int i = 0; i < 120; i++) cmd_queue.push_back(rnd_cmd());
        drain();

        // back-to-back commands
        set_inset(8'd0);
        send_idle_pct = 0;
        for (int i = 0; i < 130; i++) cmd_queue.push_back(rnd_cmd());
        drain();

        if (err_count == 0)
            $display("tb_line_rect_intersection_unit: done, clean");
        else
            $display("tb_line_rect_intersection_unit: done, errors");
        $finish;
    end

endmodule

/* line_rect_intersection_unit.f */
sv/lri_pkg.sv
sv/line_rect_intersection_unit.sv
tb/tb_line_rect_intersection_unit.sv
